// ===== design/dlm_pkg.sv =====
// Shared constants, sequencer states and fixed-point helpers for the ring modulator voice.
package dlm_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int SAMPLE_BITS_DEF      = 24;

  localparam int SINE_W = 26;   // Q24 sine, range -1.0 .. +1.0

  // Q24 fixed-point constants
  localparam logic [31:0] VB_Q      = 32'd3355443;    // 0.2
  localparam logic [31:0] VL_Q      = 32'd6710886;    // 0.4
  localparam logic [31:0] KNEE_Q    = 32'd15099494;   // 0.9
  localparam logic [31:0] CUT_Q     = 32'd13421773;   // 0.8
  localparam logic [31:0] TURN_K    = 32'd683565276;  // 2^32 / (2*pi)
  localparam logic [3:0]  MAX_HALVE = 4'd8;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q24_ONE     = 64'd16777216;

  typedef enum logic [0:0] {
    REG_SAMPLING_FREQ = 1'b0,
    REG_SINE_FREQ     = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_SINE,
    ST_AB,
    ST_SQA,
    ST_SQB,
    ST_DB,
    ST_HALF,
    ST_SCALE,
    ST_OUT,
    ST_STEPMUL,
    ST_STEPDIV,
    ST_STEPWAIT
  } state_t;

  // sin(2*pi*p/2^32) in Q24; evaluated at elaboration only
  function automatic logic signed [SINE_W-1:0] sine_of_phase(input logic [31:0] p);
    logic [1:0]  quad;
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    quad = p[31:30];
    f    = {34'd0, p[29:0]};
    if (quad[0]) begin
      f = Q30_ONE - f;
    end
    x  = (f * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd32) >> 6;
    if (s > Q24_ONE) begin
      s = Q24_ONE;
    end
    return quad[1] ? -$signed(SINE_W'(s)) : $signed(SINE_W'(s));
  endfunction

  // halve, truncating toward zero
  function automatic logic signed [31:0] half_tz(input logic signed [31:0] v);
    logic signed [31:0] adj;
    adj = v + $signed({31'd0, v[31]});
    return adj >>> 1;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // diode law on magnitude u; sq = (u - 0.2)^2 in Q48
  function automatic logic signed [31:0] diode(input logic [31:0] u, input logic [63:0] sq);
    logic [47:0] s15;
    s15 = 48'(sq[43:0]) * 48'd15;
    if (u <= VB_Q) begin
      return 32'sd0;
    end else if (u <= VL_Q) begin
      return $signed({9'd0, s15[47:25]});
    end else begin
      return $signed(32'(u * 32'd3) - KNEE_Q);
    end
  endfunction

endpackage

// ===== design/diode_ring_modulator_voice.sv =====
// Top level: ring modulator voice sequencer around a shared multiplier and a divider.
//
//  channel  | handshake            | beat
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | first_sample, second_sample
//  out      | out_valid / out_stall| out_sample
//  config   | wr_en (no wait)      | wr_index, wr_data
//
// Per input beat the sequencer normalizes by the midpoint in fold passes, then applies
// up to 8 halvings before out_valid rises; the next input beat is taken only after the
// phase-step division by sampling_freq, which is skipped at a zero sample rate. Reset
// (rst, synchronous) clears the sequencer and carrier phase and loads 44100 Hz / 188
// rad/s. in_stall is high while busy; one finished beat may wait in the output register
// meanwhile.
module diode_ring_modulator_voice #(
  parameter int SINE_TABLE_DEPTH = dlm_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int SAMPLE_BITS      = dlm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic                   wr_index,
  input  logic [17:0]            wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] first_sample,
  input  logic [SAMPLE_BITS-1:0] second_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SAMPLE_BITS-1:0] out_sample
);

  localparam int SB    = SAMPLE_BITS;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int NW    = SB + 24;   // centred magnitude in Q24
  localparam int DVD_W = 46;        // sine_freq * TURN_K
  localparam int DVS_W = 18;        // sampling_freq
  localparam logic [SB-1:0] MID  = {1'b0, {(SB - 1){1'b1}}};
  localparam logic [NW-1:0] MASK = NW'(MID);

  // config registers
  logic [17:0] sampling_freq;
  logic [15:0] sine_freq;
  logic [31:0] carrier_phase;

  dlm_pkg::state_t state, state_next;

  // datapath registers
  logic                               c_neg;
  logic [NW-1:0]                      nacc;
  logic [NW-1:0]                      qacc;
  logic [IDX_W-1:0]                   rom_addr;
  logic signed [dlm_pkg::SINE_W-1:0]  sine_q;
  logic [31:0]                        ua;
  logic [31:0]                        ub;
  logic signed [31:0]                 da;
  logic signed [31:0]                 r;
  logic [3:0]                         halve_cnt;
  logic [SB-1:0]                      out_reg;

  // arithmetic units
  logic [31:0]      mul_a;
  logic [31:0]      mul_b;
  logic [63:0]      mul_p;
  logic             div_start;
  logic [DVD_W-1:0] div_q;
  logic             div_done;

  // input front end
  logic              in_acc;
  logic [SB:0]       sum;
  logic [SB-1:0]     avg;
  logic signed [SB:0] centred;
  logic [SB-1:0]     c_mag;

  // divide by MID = 2^(SB-1)-1: N = a*2^(SB-1) + b gives a + (a+b)/MID
  logic              fold_go;
  logic [NW-1:0]     fold_q;
  logic [NW-1:0]     fold_n;

  // combinational datapath
  logic signed [31:0] x;
  logic signed [31:0] sig;
  logic signed [31:0] h;
  logic signed [31:0] a_v;
  logic signed [31:0] b_v;
  logic [31:0]        r_mag;
  logic [SB-1:0]      scaled;
  logic [SB-1:0]      o_v;
  logic               over;

  dlm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  dlm_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[DVD_W-1:0]),
    .divisor  (sampling_freq),
    .quotient (div_q),
    .done     (div_done)
  );

  dlm_sine_rom #(
    .DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (sine_q)
  );

  always_comb begin
    in_acc  = in_valid && !in_stall;
    sum     = {1'b0, first_sample} + {1'b0, second_sample};
    avg     = sum[SB:1];
    centred = $signed({1'b0, avg}) - $signed({1'b0, MID});
    c_mag   = centred[SB] ? SB'(-centred) : SB'(centred);

    fold_go = nacc > MASK;
    fold_q  = nacc >> (SB - 1);
    fold_n  = fold_q + (nacc & MASK);

    // normalized sample and ring mix
    x   = c_neg ? -$signed({5'd0, qacc[26:0]}) : $signed({5'd0, qacc[26:0]});
    sig = x <<< 2;
    h   = dlm_pkg::half_tz(32'(sine_q));
    a_v = dlm_pkg::half_tz(h + sig);
    b_v = dlm_pkg::half_tz(sig - h);

    r_mag  = dlm_pkg::mag32(r);
    over   = r_mag > dlm_pkg::CUT_Q;
    scaled = mul_p[24 +: SB];
    o_v    = r[31] ? MID - scaled : MID + scaled;
  end

  // sequencer: next state, unit operands, divider control
  always_comb begin
    state_next = state;
    in_stall   = state != dlm_pkg::ST_IDLE;
    mul_a      = carrier_phase;
    mul_b      = 32'(SINE_TABLE_DEPTH);
    div_start  = 1'b0;
    unique case (state)
      dlm_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = dlm_pkg::ST_DIVX;
        end
      end
      dlm_pkg::ST_DIVX: begin
        if (!fold_go) begin
          state_next = dlm_pkg::ST_SINE;
        end
      end
      dlm_pkg::ST_SINE: begin
        state_next = dlm_pkg::ST_AB;   // table read settles
      end
      dlm_pkg::ST_AB: begin
        state_next = dlm_pkg::ST_SQA;
      end
      dlm_pkg::ST_SQA: begin
        mul_a      = ua - dlm_pkg::VB_Q;
        mul_b      = ua - dlm_pkg::VB_Q;
        state_next = dlm_pkg::ST_SQB;
      end
      dlm_pkg::ST_SQB: begin
        mul_a      = ub - dlm_pkg::VB_Q;
        mul_b      = ub - dlm_pkg::VB_Q;
        state_next = dlm_pkg::ST_DB;
      end
      dlm_pkg::ST_DB: begin
        state_next = dlm_pkg::ST_HALF;
      end
      dlm_pkg::ST_HALF: begin
        if (!over || halve_cnt == dlm_pkg::MAX_HALVE) begin
          state_next = dlm_pkg::ST_SCALE;
        end
      end
      dlm_pkg::ST_SCALE: begin
        mul_a      = r_mag;
        mul_b      = 32'(MID);
        state_next = dlm_pkg::ST_OUT;
      end
      dlm_pkg::ST_OUT: begin
        mul_a = r_mag;
        mul_b = 32'(MID);
        if (!out_valid) begin
          state_next = dlm_pkg::ST_STEPMUL;
        end
      end
      dlm_pkg::ST_STEPMUL: begin
        mul_a      = 32'(sine_freq);
        mul_b      = dlm_pkg::TURN_K;
        state_next = dlm_pkg::ST_STEPDIV;
      end
      dlm_pkg::ST_STEPDIV: begin
        mul_a = 32'(sine_freq);
        mul_b = dlm_pkg::TURN_K;
        if (sampling_freq == 18'd0) begin
          state_next = dlm_pkg::ST_IDLE;   // zero rate: phase holds
        end else begin
          div_start  = 1'b1;
          state_next = dlm_pkg::ST_STEPWAIT;
        end
      end
      dlm_pkg::ST_STEPWAIT: begin
        if (div_done) begin
          state_next = dlm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dlm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config, carrier phase, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_freq <= 18'd44100;
      sine_freq     <= 16'd188;
      carrier_phase <= 32'd0;
      out_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        unique case (dlm_pkg::reg_idx_t'(wr_index))
          dlm_pkg::REG_SAMPLING_FREQ: sampling_freq <= wr_data;
          dlm_pkg::REG_SINE_FREQ:     sine_freq     <= wr_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == dlm_pkg::ST_OUT && !out_valid) begin
        out_valid <= 1'b1;
      end
      if (state == dlm_pkg::ST_STEPWAIT && div_done) begin
        carrier_phase <= carrier_phase + div_q[31:0];
      end
    end
  end

  // datapath payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      c_neg <= centred[SB];
      nacc  <= {c_mag, 24'd0};
      qacc  <= '0;
    end
    if (state == dlm_pkg::ST_DIVX) begin
      rom_addr <= mul_p[32 +: IDX_W];   // (phase * depth) >> 32
      if (fold_go) begin
        nacc <= fold_n;
        qacc <= qacc + fold_q;
      end else if (nacc == MASK) begin
        qacc <= qacc + NW'(1);
      end
    end
    if (state == dlm_pkg::ST_AB) begin
      ua <= dlm_pkg::mag32(a_v);
      ub <= dlm_pkg::mag32(b_v);
    end
    if (state == dlm_pkg::ST_SQB) begin
      da <= dlm_pkg::diode(ua, mul_p);
    end
    if (state == dlm_pkg::ST_DB) begin
      r         <= dlm_pkg::half_tz(da - dlm_pkg::diode(ub, mul_p));
      halve_cnt <= 4'd0;
    end
    if (state == dlm_pkg::ST_HALF && over && halve_cnt != dlm_pkg::MAX_HALVE) begin
      r         <= dlm_pkg::half_tz(r);
      halve_cnt <= halve_cnt + 4'd1;
    end
    if (state == dlm_pkg::ST_OUT && !out_valid) begin
      out_reg <= o_v;
    end
  end

  assign out_sample = out_reg;

endmodule

// ===== design/dlm_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
module dlm_mul (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    p <= 64'(a) * 64'(b);
  end

endmodule

// ===== design/dlm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module dlm_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   rem;
  logic [DVD_W-1:0] quo;
  logic [DVS_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    rem_sh = {rem[DVS_W-1:0], quo[DVD_W-1]};
    ge     = rem_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
        quo <= {quo[DVD_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== design/dlm_sine_rom.sv =====
// Full-cycle Q24 sine table, built at elaboration, registered read.
module dlm_sine_rom #(
  parameter int DEPTH = dlm_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic [$clog2(DEPTH)-1:0]         addr,
  output logic signed [dlm_pkg::SINE_W-1:0] q
);

  logic signed [dlm_pkg::SINE_W-1:0] tab [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_tab
    localparam logic [63:0] PH = (64'(i) << 32) / DEPTH;
    assign tab[i] = dlm_pkg::sine_of_phase(PH[31:0]);
  end

  always_ff @(posedge clk) begin
    q <= tab[addr];
  end

endmodule
